/* sv/sbq_pkg.sv */
package sbq_pkg;

	localparam int TAG_W   = 16;
	localparam int AREA_W  = 20;
	localparam int COLOR_W = 8;
	localparam int XY_W    = 10;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [AREA_W-1:0]  area;
		logic [COLOR_W-1:0] color;
		logic [XY_W-1:0]    x;
		logic [XY_W-1:0]    y;
	} blob_rec_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		OP_KEEP,
		OP_INSERT,
		OP_LEFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t  op;
		blob_rec_t rec;
	} cell_ctrl_t;

endpackage

/* sv/sorted_blob_queue_unit.sv */
// Sorted blob queue: up to CAPACITY blob records held largest area first in a
// row of cells, one record per cell. Insert, pop and clear act on the row as
// they are taken and their result is registered for the next cycle; find rotates the whole
// row once past the head cell, so it holds the port until the row is back in
// place, then registers its result. A new request is taken while the
// previous result is being taken. Contents of slots beyond count are
// unspecified; clear only resets the count.
module sorted_blob_queue_unit #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [sbq_pkg::TAG_W-1:0]      blob_tag,
	input  logic [sbq_pkg::AREA_W-1:0]     blob_area,
	input  logic [sbq_pkg::COLOR_W-1:0]    blob_color,
	input  logic [sbq_pkg::XY_W-1:0]       blob_x,
	input  logic [sbq_pkg::XY_W-1:0]       blob_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic                           list_empty,
	output logic                           dropped,
	output logic [sbq_pkg::TAG_W-1:0]      out_tag,
	output logic [sbq_pkg::AREA_W-1:0]     out_area,
	output logic [sbq_pkg::COLOR_W-1:0]    out_color,
	output logic [sbq_pkg::XY_W-1:0]       out_x,
	output logic [sbq_pkg::XY_W-1:0]       out_y,
	output logic [sbq_pkg::COUNT_W-1:0]    count
);
	import sbq_pkg::*;

	localparam int HW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(CAPACITY);

	typedef enum logic {
		ST_IDLE,
		ST_FIND
	} state_t;

	state_t             state_q;
	logic [HW-1:0]      held_q;
	logic [HW-1:0]      held_d;
	logic [CW-1:0]      cnt_q;
	logic [TAG_W-1:0]   key_q;
	logic               out_valid_q;
	logic               hit_q;
	logic               empty_q;
	logic               dropped_q;
	blob_rec_t          out_rec_q;
	logic [COUNT_W-1:0] count_q;

	logic       accept;
	logic       full;
	req_t       req;
	cell_ctrl_t ctrl;
	blob_rec_t  head;
	logic       head_match;

	blob_rec_t rec_w [CAPACITY];
	logic      c_w   [CAPACITY];

	assign req      = req_t'(req_type);
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign full     = held_q == HW'(CAPACITY);
	assign head     = rec_w[0];
	assign head_match = !hit_q && ({1'b0, cnt_q} < (CW+1)'(held_q)) && (head.tag == key_q);

	always_comb begin
		ctrl.op        = OP_KEEP;
		ctrl.rec.tag   = blob_tag;
		ctrl.rec.area  = blob_area;
		ctrl.rec.color = blob_color;
		ctrl.rec.x     = blob_x;
		ctrl.rec.y     = blob_y;
		held_d         = held_q;
		if (state_q == ST_FIND) begin
			ctrl.op = OP_LEFT;
		end else if (accept) begin
			case (req)
				REQ_INSERT: begin
					ctrl.op = OP_INSERT;
					if (!full) begin
						held_d = held_q + HW'(1);
					end
				end
				REQ_POP: begin
					if (held_q != '0) begin
						ctrl.op = OP_LEFT;
						held_d  = held_q - HW'(1);
					end
				end
				REQ_CLEAR: begin
					held_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sbq_cell #(
			.IDX(i),
			.HW (HW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.held     (held_q),
			.c_prev   ((i == 0) ? 1'b0 : c_w[(i == 0) ? 0 : i - 1]),
			.left_rec (rec_w[(i == 0) ? 0 : i - 1]),
			.right_rec(rec_w[(i == CAPACITY - 1) ? 0 : i + 1]),
			.c_out    (c_w[i]),
			.rec      (rec_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			cnt_q       <= '0;
			key_q       <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			empty_q     <= 1'b1;
			dropped_q   <= 1'b0;
			out_rec_q   <= '0;
			count_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						held_q    <= held_d;
						count_q   <= COUNT_W'(held_d);
						empty_q   <= held_d == '0;
						dropped_q <= (req == REQ_INSERT) && full;
						if (req == REQ_FIND) begin
							hit_q       <= 1'b0;
							out_rec_q   <= '0;
							out_valid_q <= 1'b0;
							key_q       <= blob_tag;
							cnt_q       <= '0;
							state_q     <= ST_FIND;
						end else begin
							out_valid_q <= 1'b1;
							if ((req == REQ_POP) && (held_q != '0)) begin
								hit_q     <= 1'b1;
								out_rec_q <= head;
							end else begin
								hit_q     <= 1'b0;
								out_rec_q <= '0;
							end
						end
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_FIND: begin
					// head shows slot cnt_q; the row is back in place after the last turn
					if (head_match) begin
						hit_q     <= 1'b1;
						out_rec_q <= head;
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CAPACITY - 1)) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign list_empty = empty_q;
	assign dropped    = dropped_q;
	assign out_tag    = out_rec_q.tag;
	assign out_area   = out_rec_q.area;
	assign out_color  = out_rec_q.color;
	assign out_x      = out_rec_q.x;
	assign out_y      = out_rec_q.y;
	assign count      = count_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(CAPACITY))
		else $error("record count beyond capacity");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req == REQ_INSERT) && full) |=> (held_q == HW'(CAPACITY)) && dropped_q)
		else $error("insert into full list changed the count or was not flagged");

	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req == REQ_FIND)) |=> !out_valid_q && !in_ready)
		else $error("find result shown before the rotation finished");

	a_find_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |=> $stable(held_q))
		else $error("count changed during a find");

endmodule

/* sv/sbq_cell.sv */
module sbq_cell #(
	parameter int IDX = 0,
	parameter int HW  = 7
) (
	input  logic               clk,
	input  sbq_pkg::cell_ctrl_t ctrl,
	input  logic [HW-1:0]      held,
	input  logic               c_prev,
	input  sbq_pkg::blob_rec_t left_rec,
	input  sbq_pkg::blob_rec_t right_rec,
	output logic               c_out,
	output sbq_pkg::blob_rec_t rec
);
	import sbq_pkg::*;

	blob_rec_t rec_q;
	logic      beyond;
	logic      wins;

	assign beyond = HW'(IDX) >= held;
	// head needs a strictly larger area, later slots take ties ahead of them
	assign wins   = (IDX == 0) ? (ctrl.rec.area > rec_q.area) : (ctrl.rec.area >= rec_q.area);
	assign c_out  = beyond | wins;
	assign rec    = rec_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (c_prev) begin
					rec_q <= left_rec;
				end else if (c_out) begin
					rec_q <= ctrl.rec;
				end
			end
			OP_LEFT: begin
				rec_q <= right_rec;
			end
			default: begin
			end
		endcase
	end

endmodule

/* tb/sv/sorted_blob_queue_unit_tb.sv */
module sorted_blob_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbq_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic                hit;
		logic                empty;
		logic                dropped;
		blob_rec_t           rec;
		logic [COUNT_W-1:0]  cnt;
	} blob_reply_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [1:0]          req_type   = '0;
	logic [TAG_W-1:0]    blob_tag   = '0;
	logic [AREA_W-1:0]   blob_area  = '0;
	logic [COLOR_W-1:0]  blob_color = '0;
	logic [XY_W-1:0]     blob_x     = '0;
	logic [XY_W-1:0]     blob_y     = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic                hit;
	logic                list_empty;
	logic                dropped;
	logic [TAG_W-1:0]    out_tag;
	logic [AREA_W-1:0]   out_area;
	logic [COLOR_W-1:0]  out_color;
	logic [XY_W-1:0]     out_x;
	logic [XY_W-1:0]     out_y;
	logic [COUNT_W-1:0]  count;

	// mirror of the list, head at index 0
	blob_rec_t   slots [CAPACITY];
	int unsigned held;
	blob_reply_t blob_replies[$];
	int          faults;
	int          cycles;
	bit          steady;

	sorted_blob_queue_unit #(.CAPACITY(CAPACITY)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.blob_tag   (blob_tag),
		.blob_area  (blob_area),
		.blob_color (blob_color),
		.blob_x     (blob_x),
		.blob_y     (blob_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.list_empty (list_empty),
		.dropped    (dropped),
		.out_tag    (out_tag),
		.out_area   (out_area),
		.out_color  (out_color),
		.out_x      (out_x),
		.out_y      (out_y),
		.count      (count)
	);

	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 22);
	end

	function automatic blob_reply_t blob_list_update(req_t kind, blob_rec_t rec);
		blob_reply_t rep;
		int          pos;
		int          last;
		int          i;
		bit          full;
		rep = '0;
		case (kind)
			REQ_INSERT: begin
				full = (held >= CAPACITY);
				// equal area to the head does not displace it
				if (held == 0 || rec.area > slots[0].area) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < held && rec.area < slots[pos].area)
						pos++;
				end
				last = full ? CAPACITY - 1 : held;
				for (i = last; i > pos; i--)
					slots[i] = slots[i-1];
				if (pos < CAPACITY)
					slots[pos] = rec;
				if (full)
					rep.dropped = 1'b1;
				else
					held++;
			end
			REQ_POP: begin
				if (held > 0) begin
					rep.hit = 1'b1;
					rep.rec = slots[0];
					for (i = 1; i < held; i++)
						slots[i-1] = slots[i];
					held--;
				end
			end
			REQ_FIND: begin
				for (i = 0; i < held; i++) begin
					if (slots[i].tag == rec.tag) begin
						rep.hit = 1'b1;
						rep.rec = slots[i];
						break;
					end
				end
			end
			default: begin
				held = 0;
			end
		endcase
		rep.empty = (held == 0);
		rep.cnt   = COUNT_W'(held);
		return rep;
	endfunction

	function automatic string fmt_reply(blob_reply_t r);
		return $sformatf("hit=%0b empty=%0b drop=%0b tag=%h area=%h col=%h x=%h y=%h cnt=%0d",
			r.hit, r.empty, r.dropped, r.rec.tag, r.rec.area, r.rec.color,
			r.rec.x, r.rec.y, r.cnt);
	endfunction

	function automatic void log_fault(string what);
		faults++;
		if (faults <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endfunction

	function automatic blob_rec_t blob(int unsigned tag, int unsigned area,
			int unsigned color, int unsigned x, int unsigned y);
		blob_rec_t r;
		r.tag   = TAG_W'(tag);
		r.area  = AREA_W'(area);
		r.color = COLOR_W'(color);
		r.x     = XY_W'(x);
		r.y     = XY_W'(y);
		return r;
	endfunction

	function automatic blob_rec_t rand_record();
		blob_rec_t r;
		// narrow tag pool now and then so finds see duplicates
		if ($urandom_range(1) != 0)
			r.tag = TAG_W'($urandom_range(15));
		else
			r.tag = TAG_W'($urandom);
		case ($urandom_range(9))
			0:          r.area = '1;
			1:          r.area = '0;
			2, 3, 4, 5: r.area = AREA_W'($urandom_range(31));
			default:    r.area = AREA_W'($urandom);
		endcase
		r.color = COLOR_W'($urandom);
		r.x     = XY_W'($urandom);
		r.y     = XY_W'($urandom);
		return r;
	endfunction

	// result check
	always @(posedge clk) begin : reply_check
		blob_reply_t got;
		blob_reply_t want;
		string       diff;
		if (arst_n && out_valid && out_ready) begin
			got = {hit, list_empty, dropped,
				blob_rec_t'({out_tag, out_area, out_color, out_x, out_y}), count};
			if (blob_replies.size() == 0) begin
				log_fault($sformatf("unexpected transaction: got %s", fmt_reply(got)));
			end else begin
				want = blob_replies.pop_front();
				diff = "";
				if (got.hit !== want.hit)             diff = {diff, " hit"};
				if (got.empty !== want.empty)         diff = {diff, " list_empty"};
				if (got.dropped !== want.dropped)     diff = {diff, " dropped"};
				if (got.rec.tag !== want.rec.tag)     diff = {diff, " out_tag"};
				if (got.rec.area !== want.rec.area)   diff = {diff, " out_area"};
				if (got.rec.color !== want.rec.color) diff = {diff, " out_color"};
				if (got.rec.x !== want.rec.x)         diff = {diff, " out_x"};
				if (got.rec.y !== want.rec.y)         diff = {diff, " out_y"};
				if (got.cnt !== want.cnt)             diff = {diff, " count"};
				if (diff != "")
					log_fault($sformatf("field(s)%s: expected %s, got %s",
						diff, fmt_reply(want), fmt_reply(got)));
			end
		end
	end

	task automatic send_req(req_t kind, blob_rec_t rec);
		while (!steady && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		blob_tag   <= rec.tag;
		blob_area  <= rec.area;
		blob_color <= rec.color;
		blob_x     <= rec.x;
		blob_y     <= rec.y;
		do @(posedge clk); while (!in_ready);
		blob_replies.push_back(blob_list_update(kind, rec));
	endtask

	// hold off until every outstanding transaction has been returned
	task automatic await_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (blob_replies.size() != 0);
	endtask

	task automatic send_random_req(int ins_pct);
		int        p;
		blob_rec_t rec;
		p   = $urandom_range(99);
		rec = rand_record();
		if (p < ins_pct) begin
			send_req(REQ_INSERT, rec);
		end else if (p == 99) begin
			send_req(REQ_CLEAR, rec);
		end else if (p < ins_pct + (99 - ins_pct) / 2) begin
			send_req(REQ_POP, rec);
		end else begin
			if (held != 0 && $urandom_range(9) < 7)
				rec.tag = slots[$urandom_range(held - 1)].tag;
			send_req(REQ_FIND, rec);
		end
	endtask

	task automatic test_empty_list();
		send_req(REQ_POP, blob(16'h0000, 0, 0, 0, 0));
		send_req(REQ_FIND, blob(16'h0000, 0, 0, 0, 0));
		send_req(REQ_CLEAR, blob(16'hFFFF, 20'hFFFFF, 8'hFF, 10'h3FF, 10'h3FF));
	endtask

	task automatic test_field_extremes();
		send_req(REQ_INSERT, blob(16'hFFFF, 20'hFFFFF, 8'hFF, 10'h3FF, 10'h3FF));
		send_req(REQ_INSERT, blob(16'h0000, 20'h00000, 8'h00, 10'h000, 10'h000));
		send_req(REQ_FIND, blob(16'hFFFF, 0, 0, 0, 0));
		send_req(REQ_FIND, blob(16'h0000, 0, 0, 0, 0));
		send_req(REQ_FIND, blob(16'h1234, 0, 0, 0, 0));
		send_req(REQ_POP, blob(0, 0, 0, 0, 0));
		send_req(REQ_POP, blob(0, 0, 0, 0, 0));
		send_req(REQ_POP, blob(0, 0, 0, 0, 0));
	endtask

	task automatic test_order_and_ties();
		send_req(REQ_INSERT, blob(1, 100, 8'h11, 10, 20));
		send_req(REQ_INSERT, blob(2, 100, 8'h22, 30, 40));
		send_req(REQ_INSERT, blob(3, 200, 8'h33, 50, 60));
		send_req(REQ_INSERT, blob(4, 50, 8'h44, 70, 80));
		// tie with the second entry: lands in front of the equal ones
		send_req(REQ_INSERT, blob(5, 100, 8'h55, 90, 100));
		send_req(REQ_INSERT, blob(1, 10, 8'h66, 110, 120));
		send_req(REQ_FIND, blob(1, 0, 0, 0, 0));
		send_req(REQ_POP, blob(0, 0, 0, 0, 0));
		send_req(REQ_CLEAR, blob(0, 0, 0, 0, 0));
		send_req(REQ_FIND, blob(1, 0, 0, 0, 0));
		send_req(REQ_POP, blob(0, 0, 0, 0, 0));
	endtask

	task automatic test_full_list();
		int        i;
		blob_rec_t rec;
		send_req(REQ_CLEAR, rand_record());
		for (i = 0; i < CAPACITY; i++) begin
			rec      = rand_record();
			rec.tag  = TAG_W'(i);
			rec.area = AREA_W'($urandom_range(20'hFFFFF, 64));
			send_req(REQ_INSERT, rec);
		end
		// smaller than everything: the newcomer itself falls off
		rec = rand_record();
		rec.area = '0;
		send_req(REQ_INSERT, rec);
		rec = rand_record();
		rec.area = '1;
		send_req(REQ_INSERT, rec);
		rec = rand_record();
		rec.area = slots[held - 1].area;
		send_req(REQ_INSERT, rec);
		for (i = 0; i < 4; i++) begin
			rec = rand_record();
			rec.tag = slots[$urandom_range(held - 1)].tag;
			send_req(REQ_FIND, rec);
		end
		rec = rand_record();
		rec.tag = 16'hFFFF;
		send_req(REQ_FIND, rec);
		for (i = 0; i < 3; i++)
			send_req(REQ_POP, rand_record());
	endtask

	task automatic test_random_mix();
		int seg;
		int k;
		int ins_pct;
		for (seg = 0; seg < 23; seg++) begin
			ins_pct = $urandom_range(75, 25);
			for (k = 0; k < 50; k++)
				send_random_req(ins_pct);
			if (seg == 11)
				await_drain();
		end
	endtask

	task automatic test_steady_burst();
		int k;
		steady = 1'b1;
		for (k = 0; k < 100; k++)
			send_random_req(80);
		await_drain();
		for (k = 0; k < 100; k++)
			send_random_req(40);
		steady = 1'b0;
	endtask

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		held   = 0;
		faults = 0;
		steady = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_field_extremes();
		test_order_and_ties();
		test_full_list();
		test_random_mix();
		test_steady_burst();

		await_drain();
		repeat (CAPACITY + 16) @(posedge clk);
		if (faults == 0 && blob_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
